/* rtl/core/taa_pkg.sv */
// Shared types, constants and tables for the tilt angle averager.
`timescale 1ns / 1ps
package taa_pkg;

  localparam int AvgCount    = 100;
  localparam int RingDepth   = 1000;
  localparam int CordicSteps = 16;

  // Reciprocals for the constant divisions; exact over the sum and ring total ranges.
  localparam int     AvgShift  = 24;
  localparam longint AvgRecip  = ((64'sd1 <<< AvgShift) + AvgCount - 1) / AvgCount;
  localparam int     MeanShift = 26;
  localparam longint MeanRecip = ((64'sd1 <<< (MeanShift + 16)) + RingDepth - 1) / RingDepth;

  // Register map.
  localparam logic [0:0] REG_SPAN_LOW  = 1'b0;
  localparam logic [0:0] REG_SPAN_HIGH = 1'b1;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } taa_in_t;

  typedef struct packed {
    logic signed [7:0] pitch_deg;
    logic signed [7:0] roll_deg;
    logic signed [7:0] incline_pct;
    logic              updated;
  } taa_out_t;

  // CORDIC unit request: vectoring (atan2) or rotation (tan).
  typedef struct packed {
    logic               start;
    logic               rotate;
    logic signed [47:0] x0;
    logic signed [47:0] y0;
    logic signed [31:0] z0;
  } taa_cordic_req_t;

  typedef struct packed {
    logic               done;
    logic signed [47:0] x;
    logic signed [47:0] y;
    logic signed [31:0] z;
  } taa_cordic_rsp_t;

  // atan(2^-i) in Q16 degrees.
  function automatic logic [21:0] angle_tab(input logic [3:0] i);
    case (i)
      4'd0:  angle_tab = 22'd2949120;
      4'd1:  angle_tab = 22'd1740967;
      4'd2:  angle_tab = 22'd919879;
      4'd3:  angle_tab = 22'd466945;
      4'd4:  angle_tab = 22'd234379;
      4'd5:  angle_tab = 22'd117304;
      4'd6:  angle_tab = 22'd58666;
      4'd7:  angle_tab = 22'd29335;
      4'd8:  angle_tab = 22'd14668;
      4'd9:  angle_tab = 22'd7334;
      4'd10: angle_tab = 22'd3667;
      4'd11: angle_tab = 22'd1833;
      4'd12: angle_tab = 22'd917;
      4'd13: angle_tab = 22'd458;
      4'd14: angle_tab = 22'd229;
      default: angle_tab = 22'd115;
    endcase
  endfunction

endpackage

/* rtl/core/taa_cordic.sv */
// Shared iterative CORDIC: one micro-rotation per cycle, vectoring or rotation mode.
`timescale 1ns / 1ps
module taa_cordic
  import taa_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  taa_cordic_req_t req,
  output taa_cordic_rsp_t rsp
);

  logic               busy;
  logic               finished;
  logic               rotate;
  logic [3:0]         step;
  logic signed [47:0] x, y;
  logic signed [31:0] z;
  logic               dir_pos;
  logic signed [47:0] dx, dy;
  logic signed [31:0] ang;

  assign dx      = y >>> step;
  assign dy      = x >>> step;
  assign ang     = $signed({10'd0, angle_tab(step)});
  assign dir_pos = rotate ? (z >= 0) : (y >= 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      step     <= '0;
      finished <= 1'b0;
    end else begin
      finished <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        step   <= '0;
        rotate <= req.rotate;
        x      <= req.x0;
        y      <= req.y0;
        z      <= req.z0;
      end else if (busy) begin
        if (rotate) begin
          x <= dir_pos ? x - dx : x + dx;
          y <= dir_pos ? y + dy : y - dy;
          z <= dir_pos ? z - ang : z + ang;
        end else begin
          x <= dir_pos ? x + dx : x - dx;
          y <= dir_pos ? y - dy : y + dy;
          z <= dir_pos ? z + ang : z - ang;
        end
        step <= step + 4'd1;
        if (step == 4'(CordicSteps - 1)) begin
          busy     <= 1'b0;
          finished <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = finished;
  assign rsp.x    = x;
  assign rsp.y    = y;
  assign rsp.z    = z;

endmodule

/* rtl/core/taa_divider.sv */
// Shared restoring divider: signed quotient truncated toward zero, one bit a cycle.
`timescale 1ns / 1ps
module taa_divider
  import taa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] dividend,
  input  logic signed [47:0] divisor,
  output logic               done,
  output logic signed [63:0] quotient
);

  logic        busy;
  logic [5:0]  cnt;
  logic [63:0] q;
  logic [64:0] rem;
  logic [47:0] dvs;
  logic        neg;
  logic [64:0] shifted;
  logic [64:0] trial;

  assign shifted = {rem[63:0], q[63]};
  assign trial   = shifted - {17'd0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        q    <= dividend[63] ? 64'(-dividend) : dividend;
        dvs  <= divisor[47] ? 48'(-divisor) : divisor;
        neg  <= dividend[63] ^ divisor[47];
        rem  <= '0;
      end else if (busy) begin
        if (!trial[64]) begin
          rem <= trial;
          q   <= {q[62:0], 1'b1};
        end else begin
          rem <= shifted;
          q   <= {q[62:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? -$signed(q) : $signed(q);

endmodule

/* rtl/core/tilt_angle_averager_unit.sv */
// Top level of the tilt angle averager: sequencer, ring memory and APB registers.
`timescale 1ns / 1ps
//
//  channel  | direction | handshake         | beat
//  ---------+-----------+-------------------+---------------------------------
//  in       | to block  | in_valid/in_ready | accel_x, accel_y, accel_z
//  out      | from block| out_valid/ready   | pitch, roll, incline, updated
//  apb      | to block  | psel/penable      | raw_span_low, raw_span_high
//
//  A sample's result takes three mapping divisions on the shared divider (none for a
//  zero span), two vectoring runs on the CORDIC unit, and the ring update. A
//  group-closing sample adds three reciprocal multiplies, a rotation run and a
//  percent division. After reset a clearing pass zeroes the ring. The result waits
//  in an output register; in_ready stays low until taken.
module tilt_angle_averager_unit
  import taa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  taa_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output taa_out_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Sequencer codes.
  localparam logic [4:0] S_CLEAR   = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_MAP     = 5'd2;
  localparam logic [4:0] S_MAPW    = 5'd3;
  localparam logic [4:0] S_ATAN    = 5'd4;
  localparam logic [4:0] S_ATANW   = 5'd5;
  localparam logic [4:0] S_RING    = 5'd6;
  localparam logic [4:0] S_RINGW   = 5'd7;
  localparam logic [4:0] S_AVG     = 5'd8;
  localparam logic [4:0] S_AVGW    = 5'd9;
  localparam logic [4:0] S_MEAN    = 5'd10;
  localparam logic [4:0] S_TAN     = 5'd12;
  localparam logic [4:0] S_TANW    = 5'd13;
  localparam logic [4:0] S_PCTW    = 5'd15;
  localparam logic [4:0] S_OUT     = 5'd16;

  localparam logic signed [47:0] DegQ   = 48'sd65536;
  localparam logic signed [47:0] Deg90  = 48'sd5898240;
  localparam logic signed [47:0] Deg180 = 48'sd11796480;

  logic [4:0] state;

  logic signed [15:0] span_low, span_high;
  taa_in_t            sample;
  logic [1:0]         idx;
  logic signed [24:0] axis_map [3];
  logic               first_angle;
  logic [8:0]         p_angle, r_angle;
  logic [16:0]        pitch_sum, roll_sum;
  logic [6:0]         group_count;
  logic [8:0]         ring_mem [RingDepth];
  logic [8:0]         ring_rd;
  logic [9:0]         ring_position;
  logic [18:0]        ring_total;
  logic signed [7:0]  held_pitch, held_roll, held_incline;
  logic               done_flag;
  logic               tan_neg;
  logic signed [47:0] mean_q;

  // Shared units.
  taa_cordic_req_t    creq;
  taa_cordic_rsp_t    crsp;
  logic               dstart, ddone;
  logic signed [63:0] ddividend, dquot;
  logic signed [47:0] ddivisor;

  taa_cordic u_cordic (.clk(clk), .rst(rst), .req(creq), .rsp(crsp));
  taa_divider u_div (.clk(clk), .rst(rst), .start(dstart), .dividend(ddividend),
                     .divisor(ddivisor), .done(ddone), .quotient(dquot));

  logic signed [16:0] span;
  assign span = 17'(span_high) - 17'(span_low);

  // atan2 operands for the current angle: pitch (-y,-z) then roll (-x,-z).
  logic signed [25:0] ny, nx;
  assign ny = first_angle ? -26'(axis_map[1]) : -26'(axis_map[0]);
  assign nx = -26'(axis_map[2]);

  // Group means and ring mean by reciprocal multiplication.
  logic [16:0] avg_sum_sel;
  logic [34:0] avg_prod;
  logic [52:0] mean_prod;
  assign avg_sum_sel = (state == S_AVGW) ? roll_sum : pitch_sum;
  assign avg_prod    = 35'(avg_sum_sel) * 35'(AvgRecip);
  assign mean_prod   = 53'(ring_total) * 53'(MeanRecip);

  // CORDIC result to whole-degree angle 90..449.
  logic signed [47:0] d_q;
  logic signed [31:0] deg;
  logic [8:0]         ang_fix;
  always_comb begin
    d_q = Deg180 + 48'(crsp.z);
    if (ny == 0) d_q = (nx < 0) ? 2 * Deg180 : Deg180;
    else if (nx == 0) d_q = (ny > 0) ? Deg180 + Deg90 : Deg90;
    if (d_q < 0) d_q = '0;
    deg = 32'(d_q >>> 16);
    if (deg > 360) deg = 360;
    ang_fix = (deg < 90) ? 9'(deg + 360) : 9'(deg);
  end

  // CORDIC initial vector with quadrant pre-rotation.
  logic signed [47:0] vx, vy;
  logic signed [31:0] vz;
  always_comb begin
    vx = 48'(nx) * DegQ;
    vy = 48'(ny) * DegQ;
    vz = '0;
    if (vx < 0) begin
      if (vy >= 0) begin
        vx = vy; vy = -48'(nx) * DegQ; vz = 32'(Deg90);
      end else begin
        vx = -vy; vy = 48'(nx) * DegQ; vz = -32'(Deg90);
      end
    end
  end

  // Mean wrap and clamp.
  function automatic logic signed [7:0] wrap_clamp(input logic signed [63:0] m);
    logic signed [63:0] v;
    v = (m > 180) ? m - 360 : m;
    if (v > 127) v = 127;
    if (v < -127) v = -127;
    wrap_clamp = 8'(v);
  endfunction

  // Reduce ring mean modulo 180 deg into (-90, 90].
  logic signed [47:0] m_red;
  logic signed [47:0] m_mod;
  always_comb begin
    m_mod = mean_q;
    if (m_mod >= 2 * Deg180) m_mod = m_mod - 2 * Deg180;
    if (m_mod >= Deg180) m_mod = m_mod - Deg180;
    m_red = (m_mod > Deg90) ? m_mod - Deg180 : m_mod;
  end

  logic signed [63:0] pct;
  always_comb begin
    pct = dquot;
    if (pct > 127) pct = 127;
    if (pct < -127) pct = -127;
  end

  assign in_ready = (state == S_IDLE);
  assign pready   = 1'b1;
  assign prdata   = paddr[2] ? {{16{span_high[15]}}, span_high}
                             : {{16{span_low[15]}}, span_low};

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      span_low  <= 16'sd265;
      span_high <= 16'sd402;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_SPAN_LOW:  span_low  <= pwdata[15:0];
        REG_SPAN_HIGH: span_high <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Ring memory: read address settles in S_RING, write in S_RINGW; S_CLEAR zeroes entries.
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) ring_mem[ring_position] <= '0;
    else if (state == S_RINGW) ring_mem[ring_position] <= p_angle;
    ring_rd <= ring_mem[ring_position];
  end

  always_ff @(posedge clk) begin
    creq.start <= 1'b0;
    dstart     <= 1'b0;
    if (rst) begin
      state         <= S_CLEAR;
      ring_position <= '0;
      ring_total    <= '0;
      pitch_sum     <= '0;
      roll_sum      <= '0;
      group_count   <= '0;
      held_pitch    <= '0;
      held_roll     <= '0;
      held_incline  <= '0;
      out_valid     <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (ring_position == 10'(RingDepth - 1)) begin
            ring_position <= '0;
            state         <= S_IDLE;
          end else ring_position <= ring_position + 10'd1;
        end
        S_IDLE: begin
          if (in_valid) begin
            sample <= in_data;
            idx    <= '0;
            state  <= S_MAP;
          end
        end
        S_MAP: begin
          // Hold: a zero span maps straight to zero.
          if (span == 0) begin
            axis_map[idx] <= '0;
            if (idx == 2'd2) begin first_angle <= 1'b1; state <= S_ATAN; end
            else idx <= idx + 2'd1;
          end else begin
            ddividend <= 64'((idx == 2'd0 ? 17'(sample.accel_x) :
                              idx == 2'd1 ? 17'(sample.accel_y) :
                                            17'(sample.accel_z)) - 17'(span_low)) * 64'sd180;
            ddivisor  <= 48'(span);
            dstart    <= 1'b1;
            state     <= S_MAPW;
          end
        end
        S_MAPW: begin
          if (ddone) begin
            axis_map[idx] <= 25'(dquot - 64'sd90);
            if (idx == 2'd2) begin first_angle <= 1'b1; state <= S_ATAN; end
            else begin idx <= idx + 2'd1; state <= S_MAP; end
          end
        end
        S_ATAN: begin
          creq.rotate <= 1'b0;
          creq.x0     <= vx;
          creq.y0     <= vy;
          creq.z0     <= vz;
          creq.start  <= 1'b1;
          state       <= S_ATANW;
        end
        S_ATANW: begin
          if (crsp.done) begin
            if (first_angle) begin
              p_angle     <= ang_fix;
              first_angle <= 1'b0;
              state       <= S_ATAN;
            end else begin
              r_angle <= ang_fix;
              state   <= S_RING;
            end
          end
        end
        S_RING: state <= S_RINGW;
        S_RINGW: begin
          ring_total    <= ring_total - 19'(ring_rd) + 19'(p_angle);
          ring_position <= (ring_position == 10'(RingDepth - 1)) ? '0
                           : ring_position + 10'd1;
          pitch_sum     <= pitch_sum + 17'(p_angle);
          roll_sum      <= roll_sum + 17'(r_angle);
          if (group_count == 7'(AvgCount - 1)) begin
            group_count <= '0;
            state       <= S_AVG;
          end else begin
            group_count <= group_count + 7'd1;
            done_flag   <= 1'b0;
            state       <= S_OUT;
            out_valid   <= 1'b1;
          end
        end
        S_AVG: begin
          held_pitch <= wrap_clamp(64'(avg_prod[34:AvgShift]));
          state      <= S_AVGW;
        end
        S_AVGW: begin
          held_roll <= wrap_clamp(64'(avg_prod[34:AvgShift]));
          pitch_sum <= '0;
          roll_sum  <= '0;
          state     <= S_MEAN;
        end
        S_MEAN: begin
          mean_q <= 48'(mean_prod[52:MeanShift]);
          state  <= S_TAN;
        end
        S_TAN: begin
          tan_neg     <= m_red < 0;
          creq.rotate <= 1'b1;
          creq.x0     <= 48'sd1 <<< 30;
          creq.y0     <= '0;
          creq.z0     <= 32'((m_red < 0) ? -m_red : m_red);
          creq.start  <= 1'b1;
          state       <= S_TANW;
        end
        S_TANW: begin
          if (crsp.done) begin
            if (crsp.x <= 0) begin
              held_incline <= tan_neg ? -8'sd127 : 8'sd127;
              done_flag    <= 1'b1;
              out_valid    <= 1'b1;
              state        <= S_OUT;
            end else begin
              ddividend <= 64'(crsp.y) * 64'sd100;
              ddivisor  <= crsp.x;
              dstart    <= 1'b1;
              state     <= S_PCTW;
            end
          end
        end
        S_PCTW: begin
          if (ddone) begin
            held_incline <= tan_neg ? -8'(pct) : 8'(pct);
            done_flag    <= 1'b1;
            out_valid    <= 1'b1;
            state        <= S_OUT;
          end
        end
        S_OUT: begin
          // Drop the beat once taken.
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_data.pitch_deg   = held_pitch;
  assign out_data.roll_deg    = held_roll;
  assign out_data.incline_pct = held_incline;
  assign out_data.updated     = done_flag;

  // The output beat stands exactly while the sequencer waits on it.
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid == (state == S_OUT)) else $error("out_valid out of step");
  // No sample is accepted while a result is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken with result pending");
  // Group counter stays inside its averaging span.
  a_group: assert property (@(posedge clk) disable iff (rst)
    group_count < 7'(AvgCount)) else $error("group counter overrun");
  // Ring position stays inside the ring.
  a_ring: assert property (@(posedge clk) disable iff (rst)
    ring_position < 10'(RingDepth)) else $error("ring position overrun");

endmodule

/* test/testbench.sv */
// Self-checking testbench for the tilt angle averager unit.
`timescale 1ns / 1ps
module testbench;
  import taa_pkg::*;

  localparam longint DegQ = 65536;

  // atan(2^-i) in Q16 degrees, held locally for the angle predictor.
  localparam longint AtanQ16 [16] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  localparam int AddrSpanLow  = 4 * REG_SPAN_LOW;
  localparam int AddrSpanHigh = 4 * REG_SPAN_HIGH;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  taa_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  taa_out_t    out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  tilt_angle_averager_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #2 clk = ~clk;

  // Predictor copy of the block's calibration and averaging state.
  longint      cal_low;
  longint      cal_high;
  int unsigned pitch_acc;
  int unsigned roll_acc;
  int unsigned samples_in_group;
  int unsigned pitch_hist [RingDepth];
  int unsigned hist_pos;
  int unsigned hist_total;
  logic signed [7:0] last_pitch;
  logic signed [7:0] last_roll;
  logic signed [7:0] last_incline;

  taa_out_t expected_readings [$];
  bit       failed = 1'b0;
  int       burst_left = 0;
  int       stall_mode = 0;
  int       stall_count = 0;

  function automatic longint scale_axis(longint v);
    longint span;
    span = cal_high - cal_low;
    if (span == 0) return 0;
    return (v - cal_low) * 180 / span - 90;
  endfunction

  // atan2 in Q16 degrees by vectoring CORDIC; shifts floor.
  function automatic longint vector_atan(longint ny, longint nx);
    longint x, y, t, acc, dx, dy;
    acc = 0;
    if (ny == 0) return (nx < 0) ? 180 * DegQ : 0;
    if (nx == 0) return (ny > 0) ? 90 * DegQ : -90 * DegQ;
    x = nx * DegQ;
    y = ny * DegQ;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; acc = 90 * DegQ;
      end else begin
        x = -y; y = t; acc = -90 * DegQ;
      end
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; acc += AtanQ16[i];
      end else begin
        x -= dx; y += dy; acc -= AtanQ16[i];
      end
    end
    return acc;
  endfunction

  function automatic int unsigned whole_degrees(longint ny, longint nx);
    longint d, deg;
    d = 180 * DegQ + vector_atan(ny, nx);
    if (d < 0) d = 0;
    deg = d >>> 16;
    if (deg > 360) deg = 360;
    if (deg < 90) deg += 360;
    return int'(deg);
  endfunction

  function automatic longint clip127(longint v);
    return (v > 127) ? 127 : ((v < -127) ? -127 : v);
  endfunction

  // Percent grade for an angle of 0..90 degrees by rotation CORDIC.
  function automatic longint grade_pct(longint a);
    longint x, y, z, dx, dy;
    x = longint'(1) << 30;
    y = 0;
    z = a;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= AtanQ16[i];
      end else begin
        x += dx; y -= dy; z += AtanQ16[i];
      end
    end
    if (x <= 0) return 127;
    return clip127(100 * y / x);
  endfunction

  function automatic longint incline_from_history();
    longint mean, m, r;
    bit neg;
    mean = longint'(hist_total) * DegQ / RingDepth;
    m = mean % (180 * DegQ);
    if (m > 90 * DegQ) m -= 180 * DegQ;
    neg = (m < 0);
    r = grade_pct(neg ? -m : m);
    return clip127(neg ? -r : r);
  endfunction

  function automatic logic signed [7:0] group_mean(int unsigned sum);
    longint mean;
    mean = sum / AvgCount;
    if (mean > 180) mean -= 360;
    return 8'(clip127(mean));
  endfunction

  // Advance the predictor by one sample and return the reading it gives.
  function automatic taa_out_t predict_tilt(taa_in_t s);
    longint xa, ya, za;
    int unsigned p, r, pos;
    taa_out_t o;
    xa = scale_axis(longint'(s.accel_x));
    ya = scale_axis(longint'(s.accel_y));
    za = scale_axis(longint'(s.accel_z));
    p = whole_degrees(-ya, -za);
    r = whole_degrees(-xa, -za);
    pos = (hist_pos < RingDepth) ? hist_pos : 0;
    pitch_acc += p;
    roll_acc += r;
    samples_in_group++;
    hist_total = hist_total - pitch_hist[pos] + p;
    pitch_hist[pos] = p;
    pos++;
    hist_pos = (pos >= RingDepth) ? 0 : pos;
    o.updated = 1'b0;
    if (samples_in_group >= AvgCount) begin
      last_pitch = group_mean(pitch_acc);
      last_roll = group_mean(roll_acc);
      last_incline = 8'(incline_from_history());
      pitch_acc = 0;
      roll_acc = 0;
      samples_in_group = 0;
      o.updated = 1'b1;
    end
    o.pitch_deg = last_pitch;
    o.roll_deg = last_roll;
    o.incline_pct = last_incline;
    return o;
  endfunction

  // Drive one sample beat and record its expected reading on acceptance.
  task automatic send_sample(input taa_in_t s);
    @(negedge clk);
    in_valid = 1'b1;
    in_data = s;
    do @(posedge clk); while (!in_ready);
    expected_readings.push_back(predict_tilt(s));
    // Burst accounting: drop valid for a random gap once the burst runs out.
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(5, 30) : $urandom_range(0, 3))
        @(negedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic send_axes(input int x, input int y, input int z);
    taa_in_t s;
    s.accel_x = 16'(x);
    s.accel_y = 16'(y);
    s.accel_z = 16'(z);
    send_sample(s);
  endtask

  // Lower valid, then hold off until every expected reading has come back.
  task automatic drain_readings();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_readings.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [15:0] value);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = {{16{value[15]}}, value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (addr == 3'(AddrSpanLow)) cal_low = longint'(signed'(value));
    else cal_high = longint'(signed'(value));
  endtask

  task automatic apb_check(input logic [2:0] addr, input logic [15:0] value);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b0; paddr = addr;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[15:0] !== value) begin
      $error("register %0d: expected %h, got %h", addr, value, prdata[15:0]);
      failed = 1'b1;
    end
    @(negedge clk);
    psel = 1'b0; penable = 1'b0;
  endtask

  task automatic set_span(input int lo, input int hi);
    drain_readings();
    apb_write(3'(AddrSpanLow), 16'(lo));
    apb_write(3'(AddrSpanHigh), 16'(hi));
    apb_check(3'(AddrSpanLow), 16'(lo));
    apb_check(3'(AddrSpanHigh), 16'(hi));
  endtask

  // Mostly values near the calibration span, the rest anywhere in range.
  function automatic int pick_axis();
    longint lo, hi, v;
    lo = (cal_low < cal_high) ? cal_low : cal_high;
    hi = (cal_low < cal_high) ? cal_high : cal_low;
    if ($urandom_range(0, 9) < 6 && hi - lo < 20000) begin
      v = lo - 40 + $urandom_range(0, int'(hi - lo) + 80);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return int'(v);
    end
    return int'(signed'(16'($urandom)));
  endfunction

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) send_axes(pick_axis(), pick_axis(), pick_axis());
  endtask

  task automatic test_directed();
    // Field extremes at the reset calibration.
    send_axes(-32768, -32768, -32768);
    send_axes(32767, 32767, 32767);
    send_axes(-32768, 32767, 0);
    send_axes(32767, -32768, -1);
    send_axes(0, 0, 0);
    send_axes(265, 265, 265);
    send_axes(402, 402, 402);
    // Both atan2 operands zero: angle reads as 180.
    send_axes(334, 334, 334);
    // Pitch operand zero with z positive: pitch wraps to 360.
    send_axes(402, 334, 402);
    send_axes(334, 265, 334);
    send_axes(265, 334, 265);
    send_axes(500, 100, 333);
    // Pause until every reading is back.
    drain_readings();
    // Zero span maps every axis to zero.
    set_span(-5, -5);
    send_axes(-32768, 32767, 12);
    send_axes(0, 0, 0);
  endtask

  task automatic test_span_extremes();
    set_span(-32768, 32767);
    send_random(250);
  endtask

  task automatic test_inverted_span();
    set_span(32767, -32768);
    send_random(200);
    set_span(402, 265);
    send_random(100);
  endtask

  task automatic test_zero_span();
    set_span(7, 7);
    send_random(120);
  endtask

  task automatic test_random_span();
    set_span(int'(signed'(16'($urandom))), int'(signed'(16'($urandom))));
    send_random(150);
    set_span(int'(signed'(16'($urandom_range(0, 65535)))), $urandom_range(0, 300));
    send_random(150);
  endtask

  task automatic test_default_span();
    set_span(265, 402);
    send_random(330);
  endtask

  // Receiver stall pattern: switch between no stalls, light and heavy stalls.
  always @(negedge clk) begin
    if (stall_count == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_count <= $urandom_range(20, 400);
    end else begin
      stall_count <= stall_count - 1;
    end
    case (stall_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        out_ready <= ($urandom_range(0, 9) == 0);
      end
    endcase
  end

  // Compare each reading beat with the oldest expectation.
  always @(posedge clk) begin
    taa_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        $error("unexpected reading beat %h", out_data);
        failed <= 1'b1;
      end else begin
        want = expected_readings.pop_front();
        if (out_data.pitch_deg !== want.pitch_deg) begin
          $error("pitch_deg: expected %0d, got %0d", want.pitch_deg, out_data.pitch_deg);
          failed <= 1'b1;
        end
        if (out_data.roll_deg !== want.roll_deg) begin
          $error("roll_deg: expected %0d, got %0d", want.roll_deg, out_data.roll_deg);
          failed <= 1'b1;
        end
        if (out_data.incline_pct !== want.incline_pct) begin
          $error("incline_pct: expected %0d, got %0d", want.incline_pct,
                 out_data.incline_pct);
          failed <= 1'b1;
        end
        if (out_data.updated !== want.updated) begin
          $error("updated: expected %0d, got %0d", want.updated, out_data.updated);
          failed <= 1'b1;
        end
      end
    end
  end

  initial begin
    #40ms;
    $display("tilt_angle_averager_unit verification failed");
    $finish;
  end

  initial begin
    cal_low = 265;
    cal_high = 402;
    pitch_acc = 0;
    roll_acc = 0;
    samples_in_group = 0;
    hist_pos = 0;
    hist_total = 0;
    last_pitch = '0;
    last_roll = '0;
    last_incline = '0;
    foreach (pitch_hist[i]) pitch_hist[i] = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_span_extremes();
    test_inverted_span();
    test_zero_span();
    test_random_span();
    test_default_span();
    drain_readings();
    repeat (50) @(negedge clk);
    if (!failed && expected_readings.size() == 0) begin
      $display("tilt_angle_averager_unit verification clean");
    end else begin
      $display("tilt_angle_averager_unit verification failed");
    end
    $finish;
  end

endmodule
